// ===== hw/rtl/atp_pkg.sv =====
`default_nettype none

package atp_pkg;

   localparam int CH_W    = 8;
   localparam int CH_N    = 3;
   localparam int PROD_W  = 2 * CH_W;
   localparam int STEPS   = 2;
   localparam int DIV_STAGES = CH_W / STEPS;

   localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
   localparam logic [CH_W-1:0] CH_ONE = 8'h01;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic REG_INNER = 1'b0;
   localparam logic REG_OUTER = 1'b1;

   // channel order inside the color vector
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // classified pixel as it travels from front to back
   typedef struct packed {
      logic                        change;
      logic [CH_W-1:0]             alpha_out;
      logic [CH_W-1:0]             divisor;
      logic [CH_N-1:0][CH_W-1:0]   color;
   } atp_item_type;

   typedef struct packed {
      logic almost_full;
   } atp_queue_status_type;

   typedef struct packed {
      logic                        valid;
      logic [CH_W-1:0]             alpha;
      logic [CH_N-1:0][CH_W-1:0]   color;
   } atp_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/alpha_threshold_pixel_unit.sv =====
`default_nettype none

// alpha threshold clamp for a stream of premultiplied argb pixels
// - request: pulse start with a pixel and its region flag; a transfer
//   happens at an edge where start is high and busy is low
// - inside the region alpha is raised to inner_threshold, outside it is
//   lowered to outer_threshold; changed pixels get each color scaled by
//   new/old alpha (floor, saturated at 255, zero alpha taken as 1)
// - response: rsp_valid marks each result for exactly one cycle; the
//   receiver takes it at the end of that cycle and cannot stall
// - path: the result strobe is registered through the front register,
//   queue, multiplier and four divider stages
// - throughput: one pixel per clock; the divider pipeline retires two
//   quotient bits per stage so it never holds items back
// - busy only rises if the front/back queue nears full, which does not
//   happen with the back end draining one entry every cycle
// - csr: apb, inner_threshold at 0x0, outer_threshold at 0x4, to be written
//   only while the unit is idle; the user is bound, the block does not check
// - reset: synchronous, empties the pipeline and queue and sets the
//   thresholds to 0 (inner) and 255 (outer)
module alpha_threshold_pixel_unit
   import atp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [CH_W-1:0]        req_in_alpha,
   input  wire logic [CH_W-1:0]        req_in_red,
   input  wire logic [CH_W-1:0]        req_in_green,
   input  wire logic [CH_W-1:0]        req_in_blue,
   input  wire logic                   req_inside_region,
   // response channel
   output logic                        rsp_valid,
   output logic [CH_W-1:0]             rsp_out_alpha,
   output logic [CH_W-1:0]             rsp_out_red,
   output logic [CH_W-1:0]             rsp_out_green,
   output logic [CH_W-1:0]             rsp_out_blue,
   // configuration port
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]       prdata,
   output logic                        pready
);

   logic                 accept;
   logic                 csr_write;
   logic [CH_W-1:0]      inner_ff;
   logic [CH_W-1:0]      outer_ff;
   logic                 front_valid;
   atp_item_type         front_item;
   logic                 queue_valid;
   atp_item_type         queue_item;
   atp_queue_status_type queue_status;
   atp_result_type       result;

   // request transfer
   assign accept = start && !busy;
   // front register holds one item beyond the queue, so stop one entry early
   assign busy   = queue_status.almost_full;

   // csr write transfer; paddr[2] picks the register, low bits are byte offset
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= '0;
         outer_ff <= CH_MAX;
      end else if (csr_write) begin
         if (paddr[2] == REG_INNER) begin
            inner_ff <= pwdata[CH_W-1:0];
         end else begin
            outer_ff <= pwdata[CH_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      case (paddr[2])
         REG_INNER: prdata[CH_W-1:0] = inner_ff;
         REG_OUTER: prdata[CH_W-1:0] = outer_ff;
         default:   prdata = '0;
      endcase
   end

   // classify: which threshold applies and whether the pixel changes
   atp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_alpha        (req_in_alpha),
      .in_red          (req_in_red),
      .in_green        (req_in_green),
      .in_blue         (req_in_blue),
      .inside_region   (req_inside_region),
      .inner_threshold (inner_ff),
      .outer_threshold (outer_ff),
      .item_valid      (front_valid),
      .item            (front_item)
   );

   // short decoupling queue between classifier and scaler
   atp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop_valid (queue_valid),
      .pop_item  (queue_item),
      .status    (queue_status)
   );

   // scale colors: multiply by new alpha, divide by old alpha, saturate
   atp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .result     (result)
   );

   assign rsp_valid     = result.valid;
   assign rsp_out_alpha = result.alpha;
   assign rsp_out_red   = result.color[CH_RED];
   assign rsp_out_green = result.color[CH_GREEN];
   assign rsp_out_blue  = result.color[CH_BLUE];

`ifndef NO_ASSERTIONS
   // every request transfer comes out as a result strobe
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##7 rsp_valid)
      else $error("accepted pixel produced no result");

   // and no strobe appears without a request behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 7))
      else $error("result strobe without a request");

   // alpha either passes through or lands on one of the thresholds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_alpha == $past(req_in_alpha, 7))
                 || (rsp_out_alpha == inner_ff)
                 || (rsp_out_alpha == outer_ff))
      else $error("result alpha is neither source nor threshold");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/atp_front.sv =====
`default_nettype none

module atp_front
   import atp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [CH_W-1:0]    in_alpha,
   input  wire logic [CH_W-1:0]    in_red,
   input  wire logic [CH_W-1:0]    in_green,
   input  wire logic [CH_W-1:0]    in_blue,
   input  wire logic               inside_region,
   input  wire logic [CH_W-1:0]    inner_threshold,
   input  wire logic [CH_W-1:0]    outer_threshold,
   output logic                    item_valid,
   output atp_item_type            item
);

   logic          valid_ff;
   atp_item_type  item_ff;
   atp_item_type  item_in;

   always_comb begin
      logic [CH_W-1:0] nz_alpha;
      logic            change;
      logic [CH_W-1:0] thr;
      nz_alpha = (in_alpha == '0) ? CH_ONE : in_alpha;
      if (inside_region) begin
         change = in_alpha < inner_threshold;
         thr    = inner_threshold;
      end else begin
         change = in_alpha > outer_threshold;
         thr    = outer_threshold;
      end
      item_in.change          = change;
      item_in.alpha_out       = change ? thr : in_alpha;
      item_in.divisor         = nz_alpha;
      item_in.color[CH_RED]   = in_red;
      item_in.color[CH_GREEN] = in_green;
      item_in.color[CH_BLUE]  = in_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/atp_queue.sv =====
`default_nettype none

module atp_queue
   import atp_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  atp_item_type        push_item,
   output logic                pop_valid,
   output atp_item_type        pop_item,
   output atp_queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ALMOST   = CNT_W'(DEPTH - 1);

   atp_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   // back end drains one entry every cycle it has one
   assign pop = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_valid          = pop;
   assign pop_item           = slot_ff[rd_ptr_ff];
   assign status.almost_full = (count_ff >= ALMOST);

endmodule

`default_nettype wire

// ===== hw/rtl/atp_back.sv =====
`default_nettype none

module atp_back
   import atp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      item_valid,
   input  atp_item_type   item,
   output atp_result_type result
);

   // multiply stage
   logic                      m_valid_ff;
   atp_item_type              m_item_ff;
   logic [PROD_W-1:0]         m_prod_ff [CH_N];
   logic [PROD_W-1:0]         m_prod_in [CH_N];

   // divide stages, two quotient bits each
   logic [DIV_STAGES-1:0]     d_valid_ff;
   atp_item_type              d_item_ff [DIV_STAGES];
   logic [CH_W-1:0]           d_rem_ff  [DIV_STAGES][CH_N];
   logic [CH_W-1:0]           d_rem_in  [DIV_STAGES][CH_N];
   logic [CH_W-1:0]           d_low_ff  [DIV_STAGES][CH_N];
   logic [CH_W-1:0]           d_low_in  [DIV_STAGES][CH_N];
   logic [CH_W-1:0]           d_quo_ff  [DIV_STAGES][CH_N];
   logic [CH_W-1:0]           d_quo_in  [DIV_STAGES][CH_N];
   logic                      d_sat_ff  [DIV_STAGES][CH_N];
   logic                      d_sat_in  [DIV_STAGES][CH_N];

   // what each divide stage starts from
   atp_item_type              s_item    [DIV_STAGES];
   logic [CH_W-1:0]           s_rem     [DIV_STAGES][CH_N];
   logic [CH_W-1:0]           s_low     [DIV_STAGES][CH_N];
   logic [CH_W-1:0]           s_quo     [DIV_STAGES][CH_N];
   logic                      s_sat     [DIV_STAGES][CH_N];

   always_comb begin
      for (int ch = 0; ch < CH_N; ch++) begin
         m_prod_in[ch] = {{CH_W{1'b0}}, item.color[ch]} * {{CH_W{1'b0}}, item.alpha_out};
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         m_item_ff <= item;
         for (int ch = 0; ch < CH_N; ch++) begin
            m_prod_ff[ch] <= m_prod_in[ch];
         end
      end
   end

   // first stage takes the product, later stages the previous stage
   always_comb begin
      s_item[0] = m_item_ff;
      for (int ch = 0; ch < CH_N; ch++) begin
         s_rem[0][ch] = m_prod_ff[ch][PROD_W-1:CH_W];
         s_low[0][ch] = m_prod_ff[ch][CH_W-1:0];
         s_quo[0][ch] = '0;
         // quotient above 255 is caught up front as saturation
         s_sat[0][ch] = (m_prod_ff[ch][PROD_W-1:CH_W] >= m_item_ff.divisor);
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         s_item[k] = d_item_ff[k-1];
         for (int ch = 0; ch < CH_N; ch++) begin
            s_rem[k][ch] = d_rem_ff[k-1][ch];
            s_low[k][ch] = d_low_ff[k-1][ch];
            s_quo[k][ch] = d_quo_ff[k-1][ch];
            s_sat[k][ch] = d_sat_ff[k-1][ch];
         end
      end
   end

   // restoring division
   always_comb begin
      logic [CH_W-1:0] rem;
      logic [CH_W-1:0] low;
      logic [CH_W-1:0] quo;
      logic [CH_W-1:0] div;
      logic [CH_W:0]   trial;
      for (int k = 0; k < DIV_STAGES; k++) begin
         div = s_item[k].divisor;
         for (int ch = 0; ch < CH_N; ch++) begin
            rem = s_rem[k][ch];
            low = s_low[k][ch];
            quo = s_quo[k][ch];
            for (int s = 0; s < STEPS; s++) begin
               trial = {rem, low[CH_W-1]};
               low   = {low[CH_W-2:0], 1'b0};
               if (trial >= {1'b0, div}) begin
                  trial = trial - {1'b0, div};
                  quo   = {quo[CH_W-2:0], 1'b1};
               end else begin
                  quo   = {quo[CH_W-2:0], 1'b0};
               end
               rem = trial[CH_W-1:0];
            end
            d_rem_in[k][ch] = rem;
            d_low_in[k][ch] = low;
            d_quo_in[k][ch] = quo;
            d_sat_in[k][ch] = s_sat[k][ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         d_valid_ff <= '0;
      end else begin
         m_valid_ff <= item_valid;
         d_valid_ff <= {d_valid_ff[DIV_STAGES-2:0], m_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         d_item_ff[k] <= s_item[k];
         for (int ch = 0; ch < CH_N; ch++) begin
            d_rem_ff[k][ch] <= d_rem_in[k][ch];
            d_low_ff[k][ch] <= d_low_in[k][ch];
            d_quo_ff[k][ch] <= d_quo_in[k][ch];
            d_sat_ff[k][ch] <= d_sat_in[k][ch];
         end
      end
   end

   always_comb begin
      result.valid = d_valid_ff[DIV_STAGES-1];
      result.alpha = d_item_ff[DIV_STAGES-1].alpha_out;
      for (int ch = 0; ch < CH_N; ch++) begin
         if (!d_item_ff[DIV_STAGES-1].change) begin
            result.color[ch] = d_item_ff[DIV_STAGES-1].color[ch];
         end else if (d_sat_ff[DIV_STAGES-1][ch]) begin
            result.color[ch] = CH_MAX;
         end else begin
            result.color[ch] = d_quo_ff[DIV_STAGES-1][ch];
         end
      end
   end

endmodule

`default_nettype wire
